// File: hdl/pgr_pkg.sv
// Shared types and constants for the pixel geometric remap block.
package pgr_pkg;

   localparam int COORD_BITS_DEF     = 12;
   localparam int TRIG_FRAC_BITS_DEF = 14;
   localparam int COEF_BITS          = 16;
   localparam int COLOR_BITS         = 8;
   localparam int MODE_BITS          = 3;
   localparam int CSR_INDEX_BITS     = 3;
   localparam int MAX_RESULTS        = 4;
   localparam int RES_IDX_BITS       = 2;

   // Cosine after reset is 1.0 in Q2.14.
   localparam logic signed [COEF_BITS-1:0] COS_RESET = 16'sd16384;
   localparam logic signed [COEF_BITS-1:0] SIN_RESET = 16'sd0;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_HFLIP     = 3'd0,
      MODE_VFLIP     = 3'd1,
      MODE_ROTATE    = 3'd2,
      MODE_ROT_RIGHT = 3'd3,
      MODE_MIRROR    = 3'd4,
      MODE_QUAD      = 3'd5,
      MODE_TRANSLATE = 3'd6,
      MODE_WRAP      = 3'd7
   } mode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MODE        = 3'd0,
      CSR_WIDTH       = 3'd1,
      CSR_HEIGHT      = 3'd2,
      CSR_SHIFT_RIGHT = 3'd3,
      CSR_SHIFT_DOWN  = 3'd4,
      CSR_COS         = 3'd5,
      CSR_SIN         = 3'd6
   } csr_index_type;

   typedef logic [COLOR_BITS-1:0] color_type;

   typedef struct packed {
      color_type red;
      color_type green;
      color_type blue;
   } rgb_type;

endpackage

// File: hdl/pixel_geometric_remap.sv
// Pixel geometric remap: maps one source pixel to zero to four destination pixels.
//
//   channel   ports                         transaction marker
//   -------   ---------------------------   ---------------------------------
//   request   req_src_x/y, req_*_in         start high while busy is low
//   response  rsp_dest_x/y, rsp_*_out,      rsp_valid high for one cycle
//             rsp_last_of_run
//   config    csr_index, csr_data           csr_write_en high
//
// A request passes through three register stages (input, products, rotated
// coordinates) and then loads the output register, which presents its responses.
// A pixel that yields several responses (two for mirror, four for the
// four-in-one copy) holds the output register until its last one is shown, so
// the block takes one pixel per cycle only in the single-result modes.
// The receiver cannot stall; busy rises only while the output register is
// still draining a multi-result pixel and every stage behind it is full.
// Reset is synchronous and clears the stage valid bits, the response index and
// the configuration registers; the data registers are left as they are.
module pixel_geometric_remap #(
   parameter int COORD_BITS     = pgr_pkg::COORD_BITS_DEF,
   parameter int TRIG_FRAC_BITS = pgr_pkg::TRIG_FRAC_BITS_DEF,
   localparam int CSR_DATA_BITS = (COORD_BITS + 1 > pgr_pkg::COEF_BITS) ?
                                  (COORD_BITS + 1) : pgr_pkg::COEF_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Configuration write port.
   input  logic                                  csr_write_en,
   input  logic [pgr_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [CSR_DATA_BITS-1:0]              csr_data,
   // Request channel.
   input  logic                                  start,
   output logic                                  busy,
   input  logic [COORD_BITS-1:0]                 req_src_x,
   input  logic [COORD_BITS-1:0]                 req_src_y,
   input  logic [pgr_pkg::COLOR_BITS-1:0]        req_red_in,
   input  logic [pgr_pkg::COLOR_BITS-1:0]        req_green_in,
   input  logic [pgr_pkg::COLOR_BITS-1:0]        req_blue_in,
   // Response channel.
   output logic                                  rsp_valid,
   output logic [COORD_BITS-1:0]                 rsp_dest_x,
   output logic [COORD_BITS-1:0]                 rsp_dest_y,
   output logic [pgr_pkg::COLOR_BITS-1:0]        rsp_red_out,
   output logic [pgr_pkg::COLOR_BITS-1:0]        rsp_green_out,
   output logic [pgr_pkg::COLOR_BITS-1:0]        rsp_blue_out,
   output logic                                  rsp_last_of_run
);
   import pgr_pkg::*;

   // Image dimensions carry one bit more than a coordinate so that the full
   // size (for example 4096 with 12-bit coordinates) is representable.
   localparam int DIM_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS = DIM_BITS + COEF_BITS;
   localparam int SUM_BASE  = (COORD_BITS + TRIG_FRAC_BITS > PROD_BITS) ?
                              (COORD_BITS + TRIG_FRAC_BITS) : PROD_BITS;
   localparam int SUM_BITS  = SUM_BASE + 3;
   localparam int ROT_BITS  = SUM_BITS - TRIG_FRAC_BITS;

   typedef logic [COORD_BITS-1:0] coord_type;

   // ---------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------
   mode_type                     mode_ff;
   logic [DIM_BITS-1:0]          width_ff;
   logic [DIM_BITS-1:0]          height_ff;
   coord_type                    shift_right_ff;
   coord_type                    shift_down_ff;
   logic signed [COEF_BITS-1:0]  cos_ff;
   logic signed [COEF_BITS-1:0]  sin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_HFLIP;
         width_ff       <= {1'b1, {COORD_BITS{1'b0}}};
         height_ff      <= {1'b1, {COORD_BITS{1'b0}}};
         shift_right_ff <= '0;
         shift_down_ff  <= '0;
         cos_ff         <= COS_RESET;
         sin_ff         <= SIN_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_MODE:        mode_ff        <= mode_type'(csr_data[MODE_BITS-1:0]);
            CSR_WIDTH:       width_ff       <= csr_data[DIM_BITS-1:0];
            CSR_HEIGHT:      height_ff      <= csr_data[DIM_BITS-1:0];
            CSR_SHIFT_RIGHT: shift_right_ff <= csr_data[COORD_BITS-1:0];
            CSR_SHIFT_DOWN:  shift_down_ff  <= csr_data[COORD_BITS-1:0];
            CSR_COS:         cos_ff         <= signed'(csr_data[COEF_BITS-1:0]);
            CSR_SIN:         sin_ff         <= signed'(csr_data[COEF_BITS-1:0]);
            default: ;
         endcase
      end
   end

   // Half dimensions, used by rotation, mirror and the quarter copy.
   coord_type half_w;
   coord_type half_h;
   assign half_w = width_ff[DIM_BITS-1:1];
   assign half_h = height_ff[DIM_BITS-1:1];

   // ---------------------------------------------------------------------
   // Pipeline handshake. A stage is free when it is empty or when its
   // content moves on in this cycle. The output register frees up on the
   // cycle that shows the last response of its pixel.
   // ---------------------------------------------------------------------
   logic                        p1_valid_ff, p2_valid_ff, p3_valid_ff, out_valid_ff;
   logic                        p1_valid_in, p2_valid_in, p3_valid_in, out_valid_in;
   logic                        p2_free, p3_free, out_free, out_load;
   logic                        cand_any;
   logic [RES_IDX_BITS-1:0]     cand_last;
   logic [RES_IDX_BITS-1:0]     out_idx_ff, out_idx_in, out_last_ff;

   assign out_free = !out_valid_ff || (out_idx_ff == out_last_ff);
   assign p3_free  = !p3_valid_ff || out_free;
   assign p2_free  = !p2_valid_ff || p3_free;
   assign busy     = p1_valid_ff && !p2_free;

   assign p1_valid_in  = busy ? 1'b1 : start;
   assign p2_valid_in  = p2_free ? p1_valid_ff : 1'b1;
   assign p3_valid_in  = p3_free ? p2_valid_ff : 1'b1;
   // A pixel that is dropped simply vanishes here.
   assign out_load     = out_free && p3_valid_ff && cand_any;
   assign out_valid_in = out_free ? (p3_valid_ff && cand_any) : 1'b1;
   assign out_idx_in   = out_free ? '0 : out_idx_ff + RES_IDX_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         out_idx_ff   <= '0;
      end else begin
         p1_valid_ff  <= p1_valid_in;
         p2_valid_ff  <= p2_valid_in;
         p3_valid_ff  <= p3_valid_in;
         out_valid_ff <= out_valid_in;
         out_idx_ff   <= out_idx_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: input register; the centered coordinates feed four products.
   // ---------------------------------------------------------------------
   coord_type                    p1_x_ff, p1_y_ff;
   rgb_type                      p1_rgb_ff;
   logic signed [DIM_BITS-1:0]   xc, yc;
   logic signed [PROD_BITS-1:0]  xc_cos_in, yc_sin_in, xc_sin_in, yc_cos_in;

   always_ff @(posedge clock) begin
      if (!busy) begin
         p1_x_ff   <= req_src_x;
         p1_y_ff   <= req_src_y;
         p1_rgb_ff <= '{red: req_red_in, green: req_green_in, blue: req_blue_in};
      end
   end

   assign xc = signed'({1'b0, p1_x_ff} - {1'b0, half_w});
   assign yc = signed'({1'b0, p1_y_ff} - {1'b0, half_h});

   assign xc_cos_in = PROD_BITS'(xc) * PROD_BITS'(cos_ff);
   assign yc_sin_in = PROD_BITS'(yc) * PROD_BITS'(sin_ff);
   assign xc_sin_in = PROD_BITS'(xc) * PROD_BITS'(sin_ff);
   assign yc_cos_in = PROD_BITS'(yc) * PROD_BITS'(cos_ff);

   // ---------------------------------------------------------------------
   // Stage 2: registered products; sums are formed and divided by 2^F with
   // truncation toward zero (negative sums get a bias of 2^F - 1 first).
   // ---------------------------------------------------------------------
   coord_type                    p2_x_ff, p2_y_ff;
   rgb_type                      p2_rgb_ff;
   logic signed [PROD_BITS-1:0]  p2_xc_cos_ff, p2_yc_sin_ff, p2_xc_sin_ff, p2_yc_cos_ff;
   logic signed [SUM_BITS-1:0]   base_x, base_y, sum_x, sum_y, bias_x, bias_y;
   logic signed [SUM_BITS-1:0]   adj_x, adj_y;
   logic signed [ROT_BITS-1:0]   rot_x_in, rot_y_in;

   always_ff @(posedge clock) begin
      if (p2_free) begin
         p2_x_ff      <= p1_x_ff;
         p2_y_ff      <= p1_y_ff;
         p2_rgb_ff    <= p1_rgb_ff;
         p2_xc_cos_ff <= xc_cos_in;
         p2_yc_sin_ff <= yc_sin_in;
         p2_xc_sin_ff <= xc_sin_in;
         p2_yc_cos_ff <= yc_cos_in;
      end
   end

   assign base_x = signed'(SUM_BITS'({half_w, {TRIG_FRAC_BITS{1'b0}}}));
   assign base_y = signed'(SUM_BITS'({half_h, {TRIG_FRAC_BITS{1'b0}}}));
   assign sum_x  = base_x + SUM_BITS'(p2_xc_cos_ff) - SUM_BITS'(p2_yc_sin_ff);
   assign sum_y  = base_y + SUM_BITS'(p2_xc_sin_ff) + SUM_BITS'(p2_yc_cos_ff);
   assign bias_x = sum_x[SUM_BITS-1] ? SUM_BITS'({TRIG_FRAC_BITS{1'b1}}) : '0;
   assign bias_y = sum_y[SUM_BITS-1] ? SUM_BITS'({TRIG_FRAC_BITS{1'b1}}) : '0;
   assign adj_x  = sum_x + bias_x;
   assign adj_y  = sum_y + bias_y;
   assign rot_x_in = adj_x[SUM_BITS-1:TRIG_FRAC_BITS];
   assign rot_y_in = adj_y[SUM_BITS-1:TRIG_FRAC_BITS];

   // ---------------------------------------------------------------------
   // Stage 3: every mode's destination list is built from the held pixel.
   // ---------------------------------------------------------------------
   coord_type                    p3_x_ff, p3_y_ff;
   rgb_type                      p3_rgb_ff;
   logic signed [ROT_BITS-1:0]   p3_rot_x_ff, p3_rot_y_ff;
   logic [DIM_BITS-1:0]          flip_x, flip_y, move_x, move_y, wrap_x, wrap_y;
   coord_type                    quad_x, quad_y, quad_x_hi, quad_y_hi;
   logic                         rot_inside;
   coord_type                    cand_x [MAX_RESULTS];
   coord_type                    cand_y [MAX_RESULTS];

   always_ff @(posedge clock) begin
      if (p3_free) begin
         p3_x_ff     <= p2_x_ff;
         p3_y_ff     <= p2_y_ff;
         p3_rgb_ff   <= p2_rgb_ff;
         p3_rot_x_ff <= rot_x_in;
         p3_rot_y_ff <= rot_y_in;
      end
   end

   assign flip_x = width_ff - DIM_BITS'(1) - DIM_BITS'(p3_x_ff);
   assign flip_y = height_ff - DIM_BITS'(1) - DIM_BITS'(p3_y_ff);
   assign move_x = DIM_BITS'(p3_x_ff) + DIM_BITS'(shift_right_ff);
   assign move_y = DIM_BITS'(p3_y_ff) + DIM_BITS'(shift_down_ff);
   // Wraparound takes the dimension off once only.
   assign wrap_x = (move_x >= width_ff) ? (move_x - width_ff) : move_x;
   assign wrap_y = (move_y >= height_ff) ? (move_y - height_ff) : move_y;
   assign quad_x    = p3_x_ff >> 1;
   assign quad_y    = p3_y_ff >> 1;
   assign quad_x_hi = quad_x + half_w;
   assign quad_y_hi = quad_y + half_h;
   assign rot_inside = !p3_rot_x_ff[ROT_BITS-1] && !p3_rot_y_ff[ROT_BITS-1] &&
                       ($unsigned(p3_rot_x_ff) < ROT_BITS'(width_ff)) &&
                       ($unsigned(p3_rot_y_ff) < ROT_BITS'(height_ff));

   always_comb begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         cand_x[i] = p3_x_ff;
         cand_y[i] = p3_y_ff;
      end
      cand_last = '0;
      cand_any  = 1'b1;
      unique case (mode_ff)
         MODE_HFLIP: begin
            cand_x[0] = flip_x[COORD_BITS-1:0];
         end
         MODE_VFLIP: begin
            cand_y[0] = flip_y[COORD_BITS-1:0];
         end
         MODE_ROTATE: begin
            cand_x[0] = p3_rot_x_ff[COORD_BITS-1:0];
            cand_y[0] = p3_rot_y_ff[COORD_BITS-1:0];
            cand_any  = rot_inside;
         end
         MODE_ROT_RIGHT: begin
            cand_x[0] = flip_y[COORD_BITS-1:0];
            cand_y[0] = p3_x_ff;
         end
         MODE_MIRROR: begin
            cand_x[1] = flip_x[COORD_BITS-1:0];
            cand_last = RES_IDX_BITS'(1);
            cand_any  = p3_x_ff < half_w;
         end
         MODE_QUAD: begin
            cand_x[0] = quad_x;
            cand_y[0] = quad_y;
            cand_x[1] = quad_x_hi;
            cand_y[1] = quad_y;
            cand_x[2] = quad_x;
            cand_y[2] = quad_y_hi;
            cand_x[3] = quad_x_hi;
            cand_y[3] = quad_y_hi;
            cand_last = RES_IDX_BITS'(MAX_RESULTS - 1);
         end
         MODE_TRANSLATE: begin
            cand_x[0] = move_x[COORD_BITS-1:0];
            cand_y[0] = move_y[COORD_BITS-1:0];
            cand_any  = (move_x < width_ff) && (move_y < height_ff);
         end
         MODE_WRAP: begin
            cand_x[0] = wrap_x[COORD_BITS-1:0];
            cand_y[0] = wrap_y[COORD_BITS-1:0];
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Output register: holds the destination list of one pixel and steps
   // through it, one response per cycle.
   // ---------------------------------------------------------------------
   coord_type  out_x_ff [MAX_RESULTS];
   coord_type  out_y_ff [MAX_RESULTS];
   rgb_type    out_rgb_ff;

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_x_ff    <= cand_x;
         out_y_ff    <= cand_y;
         out_rgb_ff  <= p3_rgb_ff;
         out_last_ff <= cand_last;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_dest_x      = out_x_ff[out_idx_ff];
   assign rsp_dest_y      = out_y_ff[out_idx_ff];
   assign rsp_red_out     = out_rgb_ff.red;
   assign rsp_green_out   = out_rgb_ff.green;
   assign rsp_blue_out    = out_rgb_ff.blue;
   assign rsp_last_of_run = out_idx_ff == out_last_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_idx_ff <= out_last_ff))
      else $error("response index ran past the last entry of the pixel");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_run) |=> rsp_valid)
      else $error("response run ended before its last transaction");

   a_busy_only_full: assert property (@(posedge clock) disable iff (reset)
      busy |-> (p2_valid_ff && p3_valid_ff && out_valid_ff))
      else $error("busy raised while the pipeline had a free stage");

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> p1_valid_ff)
      else $error("accepted request did not reach the input register");

   a_busy_needs_item: assert property (@(posedge clock) disable iff (reset)
      !p1_valid_ff |-> !busy)
      else $error("busy raised with an empty input register");

endmodule

// File: tb/sv/tb_pixel_geometric_remap.sv
// Self-checking testbench for the pixel geometric remap block, with a built-in predictor.
module tb_pixel_geometric_remap;
   import pgr_pkg::*;

   // Widths used by this testbench. The widest register is the 16-bit coefficient.
   localparam int COORD_W = COORD_BITS_DEF;
   localparam int FRAC_W  = TRIG_FRAC_BITS_DEF;
   localparam int CSR_W   = COEF_BITS;

   // A request passes the input, product and rotation registers before it loads
   // the output register. Up to four responses drain one per cycle after that. A
   // dropped pixel leaves no trace in the expected queue, so a quiet period of this
   // length lets it leave the pipeline before any register is changed.
   localparam int SETTLE_CYCLES = 12;

   // The run stops as a failure after this many cycles in which no transaction
   // moves on either channel. The longest correct gap is a drain plus seven register
   // writes.
   localparam int WATCHDOG_LIMIT = 1000;

   // Random pixels sent for each mode in each random phase.
   localparam int RANDOM_PER_MODE = 8;

   typedef logic [COORD_W-1:0] coord_t;

   typedef struct packed {
      coord_t  x;
      coord_t  y;
      rgb_type rgb;
   } pixel_in_t;

   typedef struct packed {
      coord_t  dest_x;
      coord_t  dest_y;
      rgb_type rgb;
      logic    last_of_run;
   } remap_result_t;

   // Every input of the block holds a known value from time zero.
   logic                      clock;
   logic                      reset        = 1'b1;
   logic                      csr_write_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index    = '0;
   logic [CSR_W-1:0]          csr_data     = '0;
   logic                      start        = 1'b0;
   logic                      busy;
   coord_t                    req_src_x    = '0;
   coord_t                    req_src_y    = '0;
   color_type                 req_red_in   = '0;
   color_type                 req_green_in = '0;
   color_type                 req_blue_in  = '0;
   logic                      rsp_valid;
   coord_t                    rsp_dest_x;
   coord_t                    rsp_dest_y;
   color_type                 rsp_red_out;
   color_type                 rsp_green_out;
   color_type                 rsp_blue_out;
   logic                      rsp_last_of_run;

   // Shadow copy of the configuration registers. Each field starts at its reset value.
   mode_type                  cfg_mode        = MODE_HFLIP;
   logic [COORD_W:0]          cfg_width       = 13'd4096;
   logic [COORD_W:0]          cfg_height      = 13'd4096;
   logic [COORD_W-1:0]        cfg_shift_right = '0;
   logic [COORD_W-1:0]        cfg_shift_down  = '0;
   logic signed [CSR_W-1:0]   cfg_cos         = COS_RESET;
   logic signed [CSR_W-1:0]   cfg_sin         = SIN_RESET;

   // Destination pixels predicted for accepted requests, oldest first.
   remap_result_t             expected_pixels[$];
   int                        mismatch_count  = 0;
   // Chance, in percent, that the sender leaves a cycle empty before a request.
   int                        sender_idle_pct = 0;

   pixel_geometric_remap i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .start           (start),
      .busy            (busy),
      .req_src_x       (req_src_x),
      .req_src_y       (req_src_y),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .rsp_valid       (rsp_valid),
      .rsp_dest_x      (rsp_dest_x),
      .rsp_dest_y      (rsp_dest_y),
      .rsp_red_out     (rsp_red_out),
      .rsp_green_out   (rsp_green_out),
      .rsp_blue_out    (rsp_blue_out),
      .rsp_last_of_run (rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   // Builds one destination pixel. A coordinate that leaves the 12-bit range
   // wraps modulo 4096, which the cast to coord_t does.
   function automatic remap_result_t place(longint col, longint row, rgb_type rgb);
      remap_result_t res;
      res.dest_x      = coord_t'(col);
      res.dest_y      = coord_t'(row);
      res.rgb         = rgb;
      res.last_of_run = 1'b0;
      return res;
   endfunction

   // Computes every destination pixel that one source pixel produces under the
   // current shadow configuration. The results are appended to the expected queue.
   function automatic void predict_remap(pixel_in_t px);
      remap_result_t hits[MAX_RESULTS];
      int            n;
      longint        x, y, w, h, hw, hh, r, d, c, s, one, sx, sy, nx, ny;
      n   = 0;
      x   = longint'(px.x);
      y   = longint'(px.y);
      w   = longint'(cfg_width);
      h   = longint'(cfg_height);
      hw  = w / 2;
      hh  = h / 2;
      r   = longint'(cfg_shift_right);
      d   = longint'(cfg_shift_down);
      c   = longint'(cfg_cos);
      s   = longint'(cfg_sin);
      one = longint'(1) << FRAC_W;
      case (cfg_mode)
         MODE_HFLIP: begin
            hits[0] = place(w - 1 - x, y, px.rgb);
            n = 1;
         end
         MODE_VFLIP: begin
            hits[0] = place(x, h - 1 - y, px.rgb);
            n = 1;
         end
         MODE_ROTATE: begin
            // The sums are exact in 64 bits. Signed division truncates toward
            // zero, as the block does.
            sx = hw * one + (x - hw) * c - (y - hh) * s;
            sy = hh * one + (x - hw) * s + (y - hh) * c;
            nx = sx / one;
            ny = sy / one;
            if (nx >= 0 && nx < w && ny >= 0 && ny < h) begin
               hits[0] = place(nx, ny, px.rgb);
               n = 1;
            end
         end
         MODE_ROT_RIGHT: begin
            hits[0] = place(h - 1 - y, x, px.rgb);
            n = 1;
         end
         MODE_MIRROR: begin
            if (x < hw) begin
               hits[0] = place(x, y, px.rgb);
               hits[1] = place(w - 1 - x, y, px.rgb);
               n = 2;
            end
         end
         MODE_QUAD: begin
            hits[0] = place(x / 2, y / 2, px.rgb);
            hits[1] = place(x / 2 + hw, y / 2, px.rgb);
            hits[2] = place(x / 2, y / 2 + hh, px.rgb);
            hits[3] = place(x / 2 + hw, y / 2 + hh, px.rgb);
            n = 4;
         end
         MODE_TRANSLATE: begin
            if (x + r < w && y + d < h) begin
               hits[0] = place(x + r, y + d, px.rgb);
               n = 1;
            end
         end
         default: begin
            // Wraparound subtracts the dimension once only, even when the
            // shift is larger than the dimension.
            nx = x + r;
            ny = y + d;
            if (nx >= w) nx -= w;
            if (ny >= h) ny -= h;
            hits[0] = place(nx, ny, px.rgb);
            n = 1;
         end
      endcase
      if (n > 0) hits[n-1].last_of_run = 1'b1;
      for (int k = 0; k < n; k++) expected_pixels.push_back(hits[k]);
   endfunction

   // ---------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------

   // Writes one register and updates the shadow copy. The block must be idle.
   // The enable is high for exactly one rising edge, and it is low again between
   // back-to-back writes.
   task automatic write_register(csr_index_type idx, logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_MODE:        cfg_mode        = mode_type'(value[MODE_BITS-1:0]);
         CSR_WIDTH:       cfg_width       = value[COORD_W:0];
         CSR_HEIGHT:      cfg_height      = value[COORD_W:0];
         CSR_SHIFT_RIGHT: cfg_shift_right = value[COORD_W-1:0];
         CSR_SHIFT_DOWN:  cfg_shift_down  = value[COORD_W-1:0];
         CSR_COS:         cfg_cos         = value;
         CSR_SIN:         cfg_sin         = value;
         default: ;
      endcase
   endtask

   // Sends one request transaction. Start stays high after acceptance. The next
   // call either loads the next pixel or lowers start, so each time step has a
   // single assignment to start. Busy is sampled just after the edge and holds its
   // value from before the edge.
   task automatic send_pixel(pixel_in_t px);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start        <= 1'b1;
      req_src_x    <= px.x;
      req_src_y    <= px.y;
      req_red_in   <= px.rgb.red;
      req_green_in <= px.rgb.green;
      req_blue_in  <= px.rgb.blue;
      do @(posedge clock); while (busy);
      predict_remap(px);
   endtask

   // Stops sending, waits for every predicted response, and then lets any dropped
   // pixel still in flight leave the pipeline.
   task automatic wait_until_idle();
      start <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic pixel_in_t pixel(int x, int y, int red, int green, int blue);
      pixel_in_t px;
      px.x         = coord_t'(x);
      px.y         = coord_t'(y);
      px.rgb.red   = color_type'(red);
      px.rgb.green = color_type'(green);
      px.rgb.blue  = color_type'(blue);
      return px;
   endfunction

   // ---------------------------------------------------------------------------
   // Random choices
   // ---------------------------------------------------------------------------

   // An image size. Most are ordinary, but zero and sizes above 4096 also occur.
   function automatic logic [CSR_W-1:0] pick_dimension();
      case ($urandom_range(9))
         0:       return 16'd1;
         1:       return 16'd2;
         2:       return 16'd4096;
         3:       return 16'd0;
         4:       return 16'($urandom_range(8191, 4097));
         5, 6:    return 16'($urandom_range(64, 1));
         default: return 16'($urandom_range(4096, 1));
      endcase
   endfunction

   // Mostly a shift that keeps the image in view. Sometimes the shift reaches or
   // passes the dimension, which covers the single-subtraction wrap.
   function automatic logic [CSR_W-1:0] pick_shift(longint dim);
      longint lim;
      lim = (dim > 4096) ? 4096 : dim;
      case ($urandom_range(5))
         0:       return '0;
         1:       return 16'd4095;
         2:       return 16'($urandom_range(4095));
         default: return (lim > 1) ? 16'($urandom_range(int'(lim) - 1)) : '0;
      endcase
   endfunction

   // Real angles such as 0, 90 and 180 degrees, arbitrary values within plus or
   // minus 1.0, and raw 16-bit patterns beyond that range.
   function automatic logic [CSR_W-1:0] pick_coef();
      case ($urandom_range(5))
         0:       return 16'd16384;
         1:       return 16'(-16384);
         2:       return '0;
         3:       return 16'($urandom);
         default: return 16'($urandom_range(32768) - 16384);
      endcase
   endfunction

   // A source coordinate. Most fall inside the image. The edges and the full
   // 12-bit range, including points outside the image, are also hit.
   function automatic coord_t pick_coord(longint dim);
      longint lim;
      lim = (dim > 4096) ? 4096 : dim;
      case ($urandom_range(9))
         0:       return coord_t'($urandom);
         1:       return '0;
         2:       return (dim > 0) ? coord_t'(dim - 1) : '1;
         default: return (lim > 0) ? coord_t'($urandom_range(int'(lim) - 1))
                                   : coord_t'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // With the reset configuration the block flips horizontally over 4096 columns.
   task automatic test_reset_state();
      sender_idle_pct = 0;
      send_pixel(pixel(0, 4095, 8'h00, 8'hFF, 8'h80));
      send_pixel(pixel(4095, 0, 8'hFF, 8'h00, 8'h7F));
   endtask

   // Each mapping on a 640 by 480 image rotated 45 degrees and shifted. Even modes
   // get the origin pixel and odd modes the far corner, which lies outside the
   // image. Every mode also gets one pixel inside the image.
   task automatic test_each_mapping();
      wait_until_idle();
      write_register(CSR_WIDTH, 16'd640);
      write_register(CSR_HEIGHT, 16'd480);
      write_register(CSR_SHIFT_RIGHT, 16'd100);
      write_register(CSR_SHIFT_DOWN, 16'd50);
      write_register(CSR_COS, 16'd11585);
      write_register(CSR_SIN, 16'd11585);
      for (int k = 0; k < 8; k++) begin
         wait_until_idle();
         write_register(CSR_MODE, 16'(mode_type'(k)));
         if (k % 2 == 0) send_pixel(pixel(0, 0, 8'h00, 8'h00, 8'h00));
         else send_pixel(pixel(4095, 4095, 8'hFF, 8'hFF, 8'hFF));
         send_pixel(pixel(100, 200, 8'hA5, 8'h5A, 8'hC3));
      end
   endtask

   // Corner cases of the arithmetic: a zero width, sizes that overflow the
   // coordinate range, a wrap with a shift larger than the image, coefficients
   // beyond 1.0, and a translated pixel that falls off the image.
   task automatic test_special_cases();
      wait_until_idle();
      write_register(CSR_MODE, 16'(MODE_HFLIP));
      write_register(CSR_WIDTH, 16'd0);
      send_pixel(pixel(5, 7, 8'h12, 8'h34, 8'h56));

      wait_until_idle();
      write_register(CSR_MODE, 16'(MODE_QUAD));
      write_register(CSR_WIDTH, 16'd8191);
      write_register(CSR_HEIGHT, 16'd8191);
      send_pixel(pixel(4095, 4095, 8'h01, 8'h80, 8'hFE));

      wait_until_idle();
      write_register(CSR_MODE, 16'(MODE_WRAP));
      write_register(CSR_WIDTH, 16'd100);
      write_register(CSR_HEIGHT, 16'd200);
      write_register(CSR_SHIFT_RIGHT, 16'd4095);
      write_register(CSR_SHIFT_DOWN, 16'd300);
      send_pixel(pixel(50, 60, 8'h33, 8'h66, 8'h99));
      send_pixel(pixel(99, 199, 8'hCC, 8'h99, 8'h66));

      wait_until_idle();
      write_register(CSR_MODE, 16'(MODE_ROTATE));
      write_register(CSR_WIDTH, 16'd4096);
      write_register(CSR_HEIGHT, 16'd4096);
      write_register(CSR_COS, 16'h8000);
      write_register(CSR_SIN, 16'h7FFF);
      send_pixel(pixel(4095, 0, 8'hF0, 8'h0F, 8'hAA));
      send_pixel(pixel(1000, 3000, 8'h55, 8'hAA, 8'h0F));

      wait_until_idle();
      write_register(CSR_MODE, 16'(MODE_TRANSLATE));
      send_pixel(pixel(1, 0, 8'h11, 8'h22, 8'h33));
      send_pixel(pixel(0, 0, 8'h44, 8'h55, 8'h66));
   endtask

   // Visits all eight modes. Each mode gets a fresh random configuration in
   // which every register is written, and then a burst of random pixels. The
   // receiver cannot hold responses off, so only the sender's idle rate varies.
   task automatic test_random_settings(int idle_pct);
      pixel_in_t px;
      sender_idle_pct = idle_pct;
      for (int k = 0; k < 8; k++) begin
         wait_until_idle();
         write_register(CSR_MODE, 16'(mode_type'(k)));
         write_register(CSR_WIDTH, pick_dimension());
         write_register(CSR_HEIGHT, pick_dimension());
         write_register(CSR_SHIFT_RIGHT, pick_shift(longint'(cfg_width)));
         write_register(CSR_SHIFT_DOWN, pick_shift(longint'(cfg_height)));
         write_register(CSR_COS, pick_coef());
         write_register(CSR_SIN, pick_coef());
         for (int j = 0; j < RANDOM_PER_MODE; j++) begin
            px.x   = pick_coord(longint'(cfg_width));
            px.y   = pick_coord(longint'(cfg_height));
            px.rgb = rgb_type'($urandom);
            send_pixel(px);
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Response checking
   // ---------------------------------------------------------------------------

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Each response is on the ports for one cycle and is taken at the edge that
   // ends that cycle. The outputs are sampled just after that edge, so they still
   // hold the values from before it.
   always @(posedge clock) begin : response_check
      remap_result_t want;
      if (!reset && rsp_valid) begin
         if (expected_pixels.size() == 0) begin
            $error("response transaction with no request waiting: dest (%0d, %0d)",
                   rsp_dest_x, rsp_dest_y);
            mismatch_count++;
         end else begin
            want = expected_pixels.pop_front();
            check_field("dest_x", want.dest_x, rsp_dest_x);
            check_field("dest_y", want.dest_y, rsp_dest_y);
            check_field("red_out", want.rgb.red, rsp_red_out);
            check_field("green_out", want.rgb.green, rsp_green_out);
            check_field("blue_out", want.rgb.blue, rsp_blue_out);
            check_field("last_of_run", want.last_of_run, rsp_last_of_run);
         end
      end
   end

   // The watchdog fails the run if no transaction moves on either channel for too
   // long. This covers a response that never comes and a busy that never falls.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (rsp_valid || (start && !busy)) quiet = 0;
         else quiet++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // Reset is held high from time zero and then released. The test sequence runs
   // after that.
   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_each_mapping();
      test_special_cases();
      test_random_settings(0);
      test_random_settings(65);
      test_random_settings(9);
      wait_until_idle();
      if (mismatch_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
